### design/assert_macros.svh
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/mlfq_pkg.sv
package mlfq_pkg;

   localparam logic [1:0] OP_ENQ  = 2'd0;
   localparam logic [1:0] OP_PICK = 2'd1;
   localparam logic [1:0] OP_REQ  = 2'd2;

   localparam logic [2:0] CSR_ACTIVE = 3'd0;
   localparam logic [2:0] CSR_QUANT0 = 3'd1;
   localparam logic [2:0] CSR_QUANT1 = 3'd2;
   localparam logic [2:0] CSR_QUANT2 = 3'd3;
   localparam logic [2:0] CSR_QUANT3 = 3'd4;

   typedef struct packed {
      logic [2:0]       active_cpus;
      logic [3:0][15:0] quantum;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  picked_task;
      logic [1:0]  picked_level;
      logic [15:0] time_slice;
      logic        went_idle;
      logic        was_stolen;
      logic        status;
   } rsp_type;

endpackage

### design/mlfq_ram.sv
module mlfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/mlfq_sched.sv
module mlfq_sched #(
   parameter int NUM_CPUS   = 4,
   parameter int NUM_LEVELS = 4,
   parameter int NUM_TASKS  = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  mlfq_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_op,
   input  logic [1:0]        req_cpu,
   input  logic [7:0]        req_task_id,
   input  logic [1:0]        req_task_level,
   input  logic [3:0]        req_task_affinity,
   input  logic              req_prev_still_running,
   output logic              res_valid,
   input  logic              res_ready,
   output mlfq_pkg::rsp_type res
);

   localparam int CW = $clog2(NUM_CPUS);
   localparam int LW = $clog2(NUM_LEVELS);
   localparam int AW = $clog2(NUM_TASKS);
   localparam int EW = $clog2(NUM_TASKS + 1);
   localparam int NW = $clog2(NUM_TASKS + 1);
   localparam int PW = 8 + LW + 4;
   localparam logic [EW-1:0] NIL = EW'(NUM_TASKS);
   localparam logic [LW-1:0] TOP_LVL = LW'(NUM_LEVELS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_ALLOC_WT, S_PUSH_A, S_PUSH_B, S_WALK, S_WALK_CHK,
      S_SCAN, S_PREV, S_PREV_WT, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [CW-1:0] cpu_ff, cpu_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [7:0]    id_ff, id_in;
   logic [3:0]    aff_ff, aff_in;
   logic          prun_ff, prun_in;
   logic [EW-1:0] free_head_ff, free_head_in;
   logic [EW-1:0] fresh_ff, fresh_in;
   logic [EW-1:0] heads_ff [NUM_CPUS][NUM_LEVELS];
   logic [EW-1:0] heads_in [NUM_CPUS][NUM_LEVELS];
   logic [EW-1:0] tails_ff [NUM_CPUS][NUM_LEVELS];
   logic [EW-1:0] tails_in [NUM_CPUS][NUM_LEVELS];
   logic [NW-1:0] cnt_ff [NUM_CPUS];
   logic [NW-1:0] cnt_in [NUM_CPUS];
   logic          run_valid_ff [NUM_CPUS];
   logic          run_valid_in [NUM_CPUS];
   logic [AW-1:0] run_entry_ff [NUM_CPUS];
   logic [AW-1:0] run_entry_in [NUM_CPUS];
   logic [CW-1:0] wcpu_ff, wcpu_in;
   logic [LW-1:0] wlvl_ff, wlvl_in;
   logic          steal_ff, steal_in;
   logic [EW-1:0] cur_ff, cur_in;
   logic [EW-1:0] prev_ff, prev_in;
   logic          found_ff, found_in;
   logic [7:0]    got_id_ff, got_id_in;
   logic [LW-1:0] got_lvl_ff, got_lvl_in;
   logic [CW:0]   scan_ff, scan_in;
   logic [CW-1:0] best_ff, best_in;
   logic [NW-1:0] max_ff, max_in;
   logic [LW-1:0] push_lvl_ff, push_lvl_in;
   logic [AW-1:0] push_e_ff, push_e_in;
   logic [EW-1:0] old_tail_ff, old_tail_in;
   mlfq_pkg::rsp_type res_ff, res_in;

   logic          pay_we, nxt_we;
   logic [AW-1:0] pay_wa, nxt_wa, rd_addr;
   logic [PW-1:0] pay_wd, pay_rd;
   logic [EW-1:0] nxt_wd, nxt_rd;
   logic [CW:0]   act;
   logic [CW-1:0] c_eff;
   logic [LW-1:0] l_eff;
   logic [LW-1:0] lvl_up, lvl_dn;
   logic [7:0]    rd_id;
   logic [LW-1:0] rd_lvl;
   logic [3:0]    rd_aff;
   logic          admit;
   logic [1:0]    qsel;
   logic          accept;

   mlfq_ram #(.WIDTH(PW), .DEPTH(NUM_TASKS)) u_pay (
      .clock(clock), .wr_en(pay_we), .wr_addr(pay_wa), .wr_data(pay_wd),
      .rd_addr(rd_addr), .rd_data(pay_rd)
   );

   mlfq_ram #(.WIDTH(EW), .DEPTH(NUM_TASKS)) u_nxt (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(rd_addr), .rd_data(nxt_rd)
   );

   always_comb begin
      int a;
      a = int'(cfg.active_cpus);
      if (a < 1) a = 1;
      if (a > NUM_CPUS) a = NUM_CPUS;
      act = (CW+1)'(a);
   end

   assign c_eff  = ({1'b0, req_cpu} >= 3'(act)) ? '0 : CW'(req_cpu);
   assign l_eff  = (int'(req_task_level) > NUM_LEVELS - 1) ? TOP_LVL : LW'(req_task_level);
   assign lvl_up = wlvl_ff + LW'(1);
   assign lvl_dn = wlvl_ff - LW'(1);
   assign {rd_id, rd_lvl, rd_aff} = pay_rd;
   assign admit  = (rd_aff == 4'd0) || rd_aff[2'(cpu_ff)];
   assign qsel   = (int'(got_lvl_ff) < 4) ? 2'(got_lvl_ff) : 2'd3;
   assign accept = req_valid && !req_stall;

   assign req_stall = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   always_comb begin
      unique case (state_ff)
         S_IDLE:  rd_addr = free_head_ff[AW-1:0];
         S_PREV:  rd_addr = run_entry_ff[cpu_ff];
         default: rd_addr = cur_ff[AW-1:0];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; cpu_in = cpu_ff; lvl_in = lvl_ff; id_in = id_ff;
      aff_in = aff_ff; prun_in = prun_ff;
      free_head_in = free_head_ff; fresh_in = fresh_ff;
      heads_in = heads_ff; tails_in = tails_ff; cnt_in = cnt_ff;
      run_valid_in = run_valid_ff; run_entry_in = run_entry_ff;
      wcpu_in = wcpu_ff; wlvl_in = wlvl_ff; steal_in = steal_ff;
      cur_in = cur_ff; prev_in = prev_ff; found_in = found_ff;
      got_id_in = got_id_ff; got_lvl_in = got_lvl_ff;
      scan_in = scan_ff; best_in = best_ff; max_in = max_ff;
      push_lvl_in = push_lvl_ff; push_e_in = push_e_ff; old_tail_in = old_tail_ff;
      res_in = res_ff;
      pay_we = 1'b0; pay_wa = push_e_ff; pay_wd = {id_ff, lvl_ff, aff_ff};
      nxt_we = 1'b0; nxt_wa = push_e_ff; nxt_wd = NIL;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_op; cpu_in = c_eff; lvl_in = l_eff; id_in = req_task_id;
               aff_in = req_task_affinity; prun_in = req_prev_still_running;
               res_in = '0;
               push_lvl_in = l_eff;
               case (req_op)
                  mlfq_pkg::OP_ENQ: begin
                     if (free_head_ff != NIL) begin
                        push_e_in = free_head_ff[AW-1:0];
                        state_in = S_ALLOC_WT;
                     end else if (fresh_ff != NIL) begin
                        push_e_in = fresh_ff[AW-1:0];
                        fresh_in = fresh_ff + EW'(1);
                        state_in = S_PUSH_A;
                     end else begin
                        res_in.status = 1'b1;
                        state_in = S_DONE;
                     end
                  end
                  mlfq_pkg::OP_PICK: begin
                     wcpu_in = c_eff; wlvl_in = '0; steal_in = 1'b0;
                     cur_in = heads_ff[c_eff][0]; prev_in = NIL; found_in = 1'b0;
                     state_in = S_WALK;
                  end
                  mlfq_pkg::OP_REQ: state_in = S_PREV;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_ALLOC_WT: begin
            free_head_in = nxt_rd;
            state_in = S_PUSH_A;
         end
         S_PUSH_A: begin
            pay_we = (op_ff == mlfq_pkg::OP_ENQ);
            nxt_we = 1'b1;
            old_tail_in = tails_ff[cpu_ff][push_lvl_ff];
            if (tails_ff[cpu_ff][push_lvl_ff] == NIL) begin
               heads_in[cpu_ff][push_lvl_ff] = EW'(push_e_ff);
            end
            tails_in[cpu_ff][push_lvl_ff] = EW'(push_e_ff);
            cnt_in[cpu_ff] = cnt_ff[cpu_ff] + NW'(1);
            state_in = S_PUSH_B;
         end
         S_PUSH_B: begin
            nxt_we = (old_tail_ff != NIL);
            nxt_wa = old_tail_ff[AW-1:0];
            nxt_wd = EW'(push_e_ff);
            state_in = S_DONE;
         end
         S_WALK: begin
            if (cur_ff != NIL) begin
               state_in = S_WALK_CHK;
            end else if (!steal_ff) begin
               if (wlvl_ff == TOP_LVL) begin
                  scan_in = '0; best_in = cpu_ff; max_in = NW'(1);
                  state_in = S_SCAN;
               end else begin
                  wlvl_in = lvl_up; cur_in = heads_ff[wcpu_ff][lvl_up];
                  prev_in = NIL;
               end
            end else begin
               if (wlvl_ff == '0) begin
                  state_in = S_PREV;
               end else begin
                  wlvl_in = lvl_dn; cur_in = heads_ff[wcpu_ff][lvl_dn];
                  prev_in = NIL;
               end
            end
         end
         S_WALK_CHK: begin
            if (admit) begin
               found_in = 1'b1; got_id_in = rd_id; got_lvl_in = rd_lvl;
               if (prev_ff == NIL) begin
                  heads_in[wcpu_ff][wlvl_ff] = nxt_rd;
               end else begin
                  nxt_we = 1'b1; nxt_wa = prev_ff[AW-1:0]; nxt_wd = nxt_rd;
               end
               if (tails_ff[wcpu_ff][wlvl_ff] == cur_ff) begin
                  tails_in[wcpu_ff][wlvl_ff] = prev_ff;
               end
               cnt_in[wcpu_ff] = cnt_ff[wcpu_ff] - NW'(1);
               state_in = S_PREV;
            end else begin
               prev_in = cur_ff; cur_in = nxt_rd;
               state_in = S_WALK;
            end
         end
         S_SCAN: begin
            if (scan_ff >= act) begin
               if (best_ff != cpu_ff) begin
                  steal_in = 1'b1; wcpu_in = best_ff; wlvl_in = TOP_LVL;
                  cur_in = heads_ff[best_ff][TOP_LVL]; prev_in = NIL;
                  state_in = S_WALK;
               end else begin
                  state_in = S_PREV;
               end
            end else begin
               if (scan_ff[CW-1:0] != cpu_ff && cnt_ff[scan_ff[CW-1:0]] > max_ff) begin
                  max_in = cnt_ff[scan_ff[CW-1:0]];
                  best_in = scan_ff[CW-1:0];
               end
               scan_in = scan_ff + (CW+1)'(1);
            end
         end
         S_PREV: begin
            // old running task first, then install the new one
            push_e_in = run_entry_ff[cpu_ff];
            state_in = S_DONE;
            if (run_valid_ff[cpu_ff]) begin
               if (op_ff == mlfq_pkg::OP_REQ || prun_ff) begin
                  state_in = S_PREV_WT;
               end else begin
                  nxt_we = 1'b1; nxt_wa = run_entry_ff[cpu_ff]; nxt_wd = free_head_ff;
                  free_head_in = EW'(run_entry_ff[cpu_ff]);
               end
            end
            if (op_ff == mlfq_pkg::OP_PICK && found_ff) begin
               run_valid_in[cpu_ff] = 1'b1;
               run_entry_in[cpu_ff] = cur_ff[AW-1:0];
               res_in.picked_task  = got_id_ff;
               res_in.picked_level = 2'(got_lvl_ff);
               res_in.time_slice   = cfg.quantum[qsel];
               res_in.was_stolen   = steal_ff;
            end else begin
               run_valid_in[cpu_ff] = 1'b0;
               run_entry_in[cpu_ff] = '0;
               res_in.went_idle = (op_ff == mlfq_pkg::OP_PICK);
            end
         end
         S_PREV_WT: begin
            push_lvl_in = rd_lvl;
            state_in = S_PUSH_A;
         end
         S_DONE: begin
            if (res_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_head_ff <= NIL;
         fresh_ff <= '0;
         for (int i = 0; i < NUM_CPUS; i++) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
               heads_ff[i][l] <= NIL;
               tails_ff[i][l] <= NIL;
            end
            cnt_ff[i] <= '0;
            run_valid_ff[i] <= 1'b0;
            run_entry_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         free_head_ff <= free_head_in;
         fresh_ff <= fresh_in;
         heads_ff <= heads_in;
         tails_ff <= tails_in;
         cnt_ff <= cnt_in;
         run_valid_ff <= run_valid_in;
         run_entry_ff <= run_entry_in;
      end
      op_ff <= op_in; cpu_ff <= cpu_in; lvl_ff <= lvl_in; id_ff <= id_in;
      aff_ff <= aff_in; prun_ff <= prun_in;
      wcpu_ff <= wcpu_in; wlvl_ff <= wlvl_in; steal_ff <= steal_in;
      cur_ff <= cur_in; prev_ff <= prev_in; found_ff <= found_in;
      got_id_ff <= got_id_in; got_lvl_ff <= got_lvl_in;
      scan_ff <= scan_in; best_ff <= best_in; max_ff <= max_in;
      push_lvl_ff <= push_lvl_in; push_e_ff <= push_e_in; old_tail_ff <= old_tail_in;
      res_ff <= res_in;
   end

endmodule

### design/mlfq_pick_with_affinity_steal_top.sv
// Multilevel feedback queue scheduler with affinity and work stealing.
// Request channel (req_*): op 0 enqueues a task on a cpu's queue at its level,
// op 1 picks the next task for a cpu (own levels 0 upward, else steal from the
// busiest other active cpu with more than one entry queued, scanning its levels
// from the lowest priority), op 2 puts the cpu's running task back on its queue.
// One response per request. Response channel (rsp_*): picked task, level, time
// slice, idle / stolen flags and status (1 = enqueue refused, task store full).
// CSR port: index 0 active_cpus, 1..4 quantum of levels 0..3; write only when
// no request is in flight.
// Sequencing: a sequencer walks linked lists held in two registered-read RAMs
// (task payload and next link). An enqueue takes a free-list or never-used entry,
// a pick walks its own levels, then steals after a scan of the active cpus, and
// the previous task is requeued when still running. One request at a time.
// Reset (synchronous): all queues empty, every cpu idle, all entries free; the
// entry RAMs are not cleared (never-used entries come from a fill counter).
// A waiting response sits in the output register; the next request is taken
// meanwhile, and the sequencer holds its result while rsp_stall keeps it full.
`include "assert_macros.svh"

module mlfq_pick_with_affinity_steal_top #(
   parameter int NUM_CPUS   = 4,
   parameter int NUM_LEVELS = 4,
   parameter int NUM_TASKS  = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [1:0]  req_cpu,
   input  logic [7:0]  req_task_id,
   input  logic [1:0]  req_task_level,
   input  logic [3:0]  req_task_affinity,
   input  logic        req_prev_still_running,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_picked_task,
   output logic [1:0]  rsp_picked_level,
   output logic [15:0] rsp_time_slice,
   output logic        rsp_went_idle,
   output logic        rsp_was_stolen,
   output logic        rsp_status
);

   mlfq_pkg::cfg_type cfg_ff;
   mlfq_pkg::rsp_type res, rsp_ff;
   logic res_valid, res_ready, rsp_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_cpus <= 3'd1;
         cfg_ff.quantum <= {4{16'd1}};
      end else if (csr_wr_en) begin
         unique case (csr_index) inside
            mlfq_pkg::CSR_ACTIVE: cfg_ff.active_cpus <= csr_wr_data[2:0];
            mlfq_pkg::CSR_QUANT0, mlfq_pkg::CSR_QUANT1,
            mlfq_pkg::CSR_QUANT2, mlfq_pkg::CSR_QUANT3:
               cfg_ff.quantum[2'(csr_index - mlfq_pkg::CSR_QUANT0)] <= csr_wr_data;
            default: ;
         endcase
      end
   end

   mlfq_sched #(
      .NUM_CPUS(NUM_CPUS), .NUM_LEVELS(NUM_LEVELS), .NUM_TASKS(NUM_TASKS)
   ) u_sched (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_cpu(req_cpu), .req_task_id(req_task_id), .req_task_level(req_task_level),
      .req_task_affinity(req_task_affinity),
      .req_prev_still_running(req_prev_still_running),
      .res_valid(res_valid), .res_ready(res_ready), .res(res)
   );

   // output register, refilled as soon as the consumer takes the old response
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_picked_task  = rsp_ff.picked_task;
   assign rsp_picked_level = rsp_ff.picked_level;
   assign rsp_time_slice   = rsp_ff.time_slice;
   assign rsp_went_idle    = rsp_ff.went_idle;
   assign rsp_was_stolen   = rsp_ff.was_stolen;
   assign rsp_status       = rsp_ff.status;

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request accepted while sequencer idle next cycle")
   `ASSERT_IMP(a_idle_fields_zero, clock, reset, rsp_valid && rsp_went_idle, rsp_time_slice == 16'd0 && !rsp_was_stolen && rsp_picked_task == 8'd0, "idle response carries pick data")
   `ASSERT_IMP(a_status_not_idle, clock, reset, rsp_valid && rsp_status, !rsp_went_idle && !rsp_was_stolen, "refused enqueue flagged as pick")

endmodule
